### rtl/cluster_free_list_allocator_macros.svh
// Assertion macros used by the allocator top level.
`ifndef CLUSTER_FREE_LIST_ALLOCATOR_MACROS_SVH
`define CLUSTER_FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define CFLA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CFLA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CFLA_ASSERT(label, clk, rst_n, prop, msg)
`define CFLA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

### rtl/cfla_pkg.sv
package cfla_pkg;

	localparam int FUNC_W    = 3;
	localparam int CLUSTER_W = 10;
	localparam int COUNT_W   = 5;
	localparam int TAG_W     = 8;
	localparam int STATUS_W  = 4;

	localparam int NUM_CLUSTERS = 1024;
	localparam int MAX_BATCH    = 16;
	localparam int WAIT_DEPTH   = 8;

	localparam int RING_AW  = $clog2(NUM_CLUSTERS);
	localparam int FCOUNT_W = $clog2(NUM_CLUSTERS + 1);

	localparam int MAP_W    = 32;
	localparam int MAP_BW   = 5;
	localparam int MAP_ROWS = (NUM_CLUSTERS + MAP_W - 1) / MAP_W;
	localparam int MAP_AW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

	localparam int WAW     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WFILL_W = $clog2(WAIT_DEPTH + 1);

	localparam int QUEUE_DEPTH = 2;

	localparam logic [FUNC_W-1:0] FN_ALLOC          = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ALLOC_WAIT     = 3'd1;
	localparam logic [FUNC_W-1:0] FN_FREE           = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR          = 3'd3;
	localparam logic [FUNC_W-1:0] FN_LOAD_FREE      = 3'd4;
	localparam logic [FUNC_W-1:0] FN_LOAD_ALLOCATED = 3'd5;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED      = 4'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE      = 4'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED         = 4'd2;
	localparam logic [STATUS_W-1:0] ST_FREED          = 4'd3;
	localparam logic [STATUS_W-1:0] ST_WAITER_GRANT   = 4'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE       = 4'd5;
	localparam logic [STATUS_W-1:0] ST_WAIT_REJECTED  = 4'd6;
	localparam logic [STATUS_W-1:0] ST_LOADED         = 4'd7;
	localparam logic [STATUS_W-1:0] ST_CLEAR_REJECTED = 4'd8;

	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] K_NONE       = 3'd0;
	localparam logic [KIND_W-1:0] K_ALLOC      = 3'd1;
	localparam logic [KIND_W-1:0] K_WAIT       = 3'd2;
	localparam logic [KIND_W-1:0] K_FREE       = 3'd3;
	localparam logic [KIND_W-1:0] K_CLEAR      = 3'd4;
	localparam logic [KIND_W-1:0] K_LOAD_FREE  = 3'd5;
	localparam logic [KIND_W-1:0] K_LOAD_ALLOC = 3'd6;

	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [CLUSTER_W-1:0] cluster;
		logic [COUNT_W-1:0]   count;
		logic [TAG_W-1:0]     tag;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [CLUSTER_W-1:0] cluster_out;
		logic [TAG_W-1:0]     tag_out;
		logic                 last;
	} rsp_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic                 bad;
		logic [CLUSTER_W-1:0] cluster;
		logic [COUNT_W-1:0]   count;
		logic [TAG_W-1:0]     tag;
	} op_t;

	typedef struct packed {
		logic                sweeping;
		logic [FCOUNT_W-1:0] free_count;
		logic [WFILL_W-1:0]  waiter_fill;
	} back_status_t;

endpackage

### rtl/cluster_free_list_allocator.sv
// Cluster free-list allocator. Request words pass through a two-word queue to an
// execution engine that owns the free ring (one RAM entry per cluster) and the
// allocation bitmap (rows of 32 bits in a second RAM). Clear, bad requests,
// queued and rejected batch requests are answered straight from the idle state;
// free, load_free and load_allocated first read the bitmap row, then check and
// write it. Every cluster handed out takes a ring read followed by a bitmap
// read-modify-write, and a woken waiter's grant starts after its free. After
// reset and after each successful clear the bitmap is swept, one row a cycle;
// req_ready is low while it runs. Results leave through a one-word output
// register.
`include "cluster_free_list_allocator_macros.svh"

module cluster_free_list_allocator import cfla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic         push;
	op_t          push_op;
	logic         pop;
	op_t          head_op;
	logic         q_empty;
	logic         q_full;
	back_status_t bstat;

	cfla_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.sweeping  (bstat.sweeping),
		.push      (push),
		.push_op   (push_op)
	);

	cfla_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.empty   (q_empty),
		.full    (q_full)
	);

	cfla_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_op      (head_op),
		.q_pop     (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.status    (bstat)
	);

	`CFLA_ASSERT_NEVER(a_no_accept_in_sweep, clk, arst_n, req_ready && bstat.sweeping, "word accepted during bitmap sweep")
	`CFLA_ASSERT(a_free_count_bound, clk, arst_n, int'(bstat.free_count) <= NUM_CLUSTERS, "free count beyond cluster total")
	`CFLA_ASSERT(a_waiter_fill_bound, clk, arst_n, int'(bstat.waiter_fill) <= WAIT_DEPTH, "waiter queue overfilled")
	`CFLA_ASSERT_NEVER(a_push_when_full, clk, arst_n, push && q_full && !pop, "push into full queue")

endmodule

### rtl/cfla_ram.sv
module cfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/cfla_front.sv
module cfla_front import cfla_pkg::*; (
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	input  logic q_full,
	input  logic sweeping,
	output logic push,
	output op_t  push_op
);

	logic in_range;
	logic bad_count;

	assign req_ready = !q_full && !sweeping;
	assign in_range  = 32'(req.cluster) < NUM_CLUSTERS;
	assign bad_count = (req.count == '0) || (32'(req.count) > MAX_BATCH)
		|| (32'(req.count) > NUM_CLUSTERS);

	always_comb begin
		push_op.cluster = req.cluster;
		push_op.count   = req.count;
		push_op.tag     = req.tag;
		push_op.bad     = 1'b0;
		unique case (req.func)
			FN_ALLOC: begin
				push_op.kind = K_ALLOC;
			end
			FN_ALLOC_WAIT: begin
				push_op.kind = K_WAIT;
				push_op.bad  = bad_count;
			end
			FN_FREE: begin
				push_op.kind = K_FREE;
				push_op.bad  = !in_range;
			end
			FN_CLEAR: begin
				push_op.kind = K_CLEAR;
			end
			FN_LOAD_FREE: begin
				push_op.kind = K_LOAD_FREE;
				push_op.bad  = !in_range;
			end
			FN_LOAD_ALLOCATED: begin
				push_op.kind = K_LOAD_ALLOC;
				push_op.bad  = !in_range;
			end
			default: begin
				push_op.kind = K_NONE;
			end
		endcase
	end

	// drop words with unused codes
	assign push = req_valid && req_ready && (push_op.kind != K_NONE);

endmodule

### rtl/cfla_queue.sv
module cfla_queue import cfla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head_op,
	output logic empty,
	output logic full
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	op_t            entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] fill_q;

	function automatic logic [QAW-1:0] q_next(input logic [QAW-1:0] p);
		return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == QCW'(QUEUE_DEPTH));
	assign head_op = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= q_next(wr_q);
			end
			if (pop) begin
				rd_q <= q_next(rd_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_op;
		end
	end

endmodule

### rtl/cfla_back.sv
module cfla_back import cfla_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  op_t          q_op,
	output logic         q_pop,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	output rsp_t         rsp,
	output back_status_t status
);

	localparam int SW = 3;
	localparam logic [SW-1:0] S_SWEEP   = 3'd0;
	localparam logic [SW-1:0] S_IDLE    = 3'd1;
	localparam logic [SW-1:0] S_POP_MAP = 3'd2;
	localparam logic [SW-1:0] S_POP_WR  = 3'd3;
	localparam logic [SW-1:0] S_MAP_CHK = 3'd4;
	localparam logic [SW-1:0] S_WAKE    = 3'd5;

	logic [SW-1:0]        state_q, state_d;
	logic [RING_AW-1:0]   head_q, head_d;
	logic [RING_AW-1:0]   tail_q, tail_d;
	logic [FCOUNT_W-1:0]  fcount_q, fcount_d;
	logic [WAW-1:0]       whead_q, whead_d;
	logic [WFILL_W-1:0]   wfill_q, wfill_d;
	logic [MAP_AW-1:0]    sweep_row_q, sweep_row_d;
	logic [COUNT_W-1:0]   cnt_q, cnt_d;
	logic                 out_valid_q, out_valid_d;

	logic [COUNT_W-1:0]   wcnt_q [WAIT_DEPTH];
	logic [TAG_W-1:0]     wtag_q [WAIT_DEPTH];
	logic [TAG_W-1:0]     tag_q, tag_d;
	logic [STATUS_W-1:0]  st_q, st_d;
	logic [CLUSTER_W-1:0] pop_cl_q, pop_cl_d;
	op_t                  op_q, op_d;
	rsp_t                 out_q;

	logic                 wq_we;
	logic [WAW-1:0]       wq_slot;

	logic                 ring_we, ring_re;
	logic [RING_AW-1:0]   ring_waddr, ring_raddr;
	logic [CLUSTER_W-1:0] ring_wdata, ring_rdata;
	logic                 map_we, map_re;
	logic [MAP_AW-1:0]    map_waddr, map_raddr;
	logic [MAP_W-1:0]     map_wdata, map_rdata;

	logic                 out_free;
	logic                 emit;
	rsp_t                 emit_rsp;
	logic                 map_bit;
	logic                 wake;
	int                   slot_sum;

	function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
		return (p == RING_AW'(NUM_CLUSTERS - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [WAW-1:0] wait_next(input logic [WAW-1:0] p);
		return (p == WAW'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [MAP_AW-1:0] map_row(input logic [CLUSTER_W-1:0] c);
		return MAP_AW'(c >> MAP_BW);
	endfunction

	cfla_ram #(.WIDTH(CLUSTER_W), .DEPTH(NUM_CLUSTERS)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	cfla_ram #(.WIDTH(MAP_W), .DEPTH(MAP_ROWS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	assign out_free = !out_valid_q || rsp_ready;
	assign map_bit  = map_rdata[op_q.cluster[MAP_BW-1:0]];
	assign wake     = (wfill_q != '0) && ((int'(fcount_q) + 1) >= int'(wcnt_q[whead_q]));

	always_comb begin
		slot_sum = int'(whead_q) + int'(wfill_q);
		if (slot_sum >= WAIT_DEPTH) begin
			slot_sum = slot_sum - WAIT_DEPTH;
		end
		wq_slot = WAW'(slot_sum);
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		fcount_d    = fcount_q;
		whead_d     = whead_q;
		wfill_d     = wfill_q;
		sweep_row_d = sweep_row_q;
		cnt_d       = cnt_q;
		tag_d       = tag_q;
		st_d        = st_q;
		pop_cl_d    = pop_cl_q;
		op_d        = op_q;
		q_pop       = 1'b0;
		wq_we       = 1'b0;
		ring_we     = 1'b0;
		ring_re     = 1'b0;
		ring_waddr  = tail_q;
		ring_raddr  = head_q;
		ring_wdata  = op_q.cluster;
		map_we      = 1'b0;
		map_re      = 1'b0;
		map_waddr   = map_row(op_q.cluster);
		map_raddr   = map_row(q_op.cluster);
		map_wdata   = map_rdata;
		emit        = 1'b0;
		emit_rsp    = '{status: ST_LOADED, cluster_out: '0, tag_out: '0, last: 1'b1};

		unique case (state_q)
			S_SWEEP: begin
				map_we    = 1'b1;
				map_waddr = sweep_row_q;
				map_wdata = '0;
				if (sweep_row_q == MAP_AW'(MAP_ROWS - 1)) begin
					state_d = S_IDLE;
				end else begin
					sweep_row_d = sweep_row_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (!q_empty) begin
					unique case (q_op.kind) inside
						K_ALLOC: begin
							if (fcount_q == '0) begin
								if (out_free) begin
									q_pop           = 1'b1;
									emit            = 1'b1;
									emit_rsp.status = ST_NONE_FREE;
								end
							end else begin
								q_pop    = 1'b1;
								ring_re  = 1'b1;
								head_d   = ring_next(head_q);
								fcount_d = fcount_q - 1'b1;
								cnt_d    = COUNT_W'(1);
								tag_d    = '0;
								st_d     = ST_ALLOCATED;
								state_d  = S_POP_MAP;
							end
						end
						K_WAIT: begin
							if (q_op.bad || ((wfill_q != '0 || int'(fcount_q) < int'(q_op.count))
									&& int'(wfill_q) >= WAIT_DEPTH)) begin
								if (out_free) begin
									q_pop           = 1'b1;
									emit            = 1'b1;
									emit_rsp.status = ST_WAIT_REJECTED;
								end
							end else if (wfill_q == '0 && int'(fcount_q) >= int'(q_op.count)) begin
								q_pop    = 1'b1;
								ring_re  = 1'b1;
								head_d   = ring_next(head_q);
								fcount_d = fcount_q - 1'b1;
								cnt_d    = q_op.count;
								tag_d    = q_op.tag;
								st_d     = ST_ALLOCATED;
								state_d  = S_POP_MAP;
							end else if (out_free) begin
								q_pop            = 1'b1;
								wq_we            = 1'b1;
								wfill_d          = wfill_q + 1'b1;
								emit             = 1'b1;
								emit_rsp.status  = ST_QUEUED;
								emit_rsp.tag_out = q_op.tag;
							end
						end
						K_FREE, K_LOAD_FREE, K_LOAD_ALLOC: begin
							if (q_op.bad) begin
								if (out_free) begin
									q_pop                = 1'b1;
									emit                 = 1'b1;
									emit_rsp.status      = ST_BAD_FREE;
									emit_rsp.cluster_out = q_op.cluster;
								end
							end else begin
								q_pop   = 1'b1;
								map_re  = 1'b1;
								op_d    = q_op;
								state_d = S_MAP_CHK;
							end
						end
						K_CLEAR: begin
							if (out_free) begin
								q_pop = 1'b1;
								emit  = 1'b1;
								if (wfill_q != '0) begin
									emit_rsp.status = ST_CLEAR_REJECTED;
								end else begin
									head_d      = '0;
									tail_d      = '0;
									fcount_d    = '0;
									sweep_row_d = '0;
									state_d     = S_SWEEP;
								end
							end
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			S_POP_MAP: begin
				pop_cl_d  = ring_rdata;
				map_re    = 1'b1;
				map_raddr = map_row(ring_rdata);
				state_d   = S_POP_WR;
			end
			S_POP_WR: begin
				if (out_free) begin
					map_we                             = 1'b1;
					map_waddr                          = map_row(pop_cl_q);
					map_wdata[pop_cl_q[MAP_BW-1:0]]    = 1'b1;
					emit                               = 1'b1;
					emit_rsp.status                    = st_q;
					emit_rsp.cluster_out               = pop_cl_q;
					emit_rsp.tag_out                   = tag_q;
					emit_rsp.last                      = (cnt_q == COUNT_W'(1));
					if (cnt_q == COUNT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						cnt_d    = cnt_q - 1'b1;
						ring_re  = 1'b1;
						head_d   = ring_next(head_q);
						fcount_d = fcount_q - 1'b1;
						state_d  = S_POP_MAP;
					end
				end
			end
			S_MAP_CHK: begin
				if (out_free) begin
					emit                 = 1'b1;
					emit_rsp.cluster_out = op_q.cluster;
					state_d              = S_IDLE;
					unique case (op_q.kind) inside
						K_FREE, K_LOAD_FREE: begin
							if ((op_q.kind == K_FREE) == !map_bit
									|| int'(fcount_q) >= NUM_CLUSTERS) begin
								emit_rsp.status = ST_BAD_FREE;
							end else begin
								if (op_q.kind == K_FREE) begin
									map_we                              = 1'b1;
									map_wdata[op_q.cluster[MAP_BW-1:0]] = 1'b0;
									emit_rsp.status                     = ST_FREED;
								end else begin
									emit_rsp.status = ST_LOADED;
								end
								ring_we       = 1'b1;
								tail_d        = ring_next(tail_q);
								fcount_d      = fcount_q + 1'b1;
								emit_rsp.last = !wake;
								if (wake) begin
									cnt_d   = wcnt_q[whead_q];
									tag_d   = wtag_q[whead_q];
									st_d    = ST_WAITER_GRANT;
									whead_d = wait_next(whead_q);
									wfill_d = wfill_q - 1'b1;
									state_d = S_WAKE;
								end
							end
						end
						K_LOAD_ALLOC: begin
							map_we                              = 1'b1;
							map_wdata[op_q.cluster[MAP_BW-1:0]] = 1'b1;
							emit_rsp.status                     = ST_LOADED;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			S_WAKE: begin
				ring_re  = 1'b1;
				head_d   = ring_next(head_q);
				fcount_d = fcount_q - 1'b1;
				state_d  = S_POP_MAP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		out_valid_d = out_valid_q;
		if (emit) begin
			out_valid_d = 1'b1;
		end else if (rsp_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			head_q      <= '0;
			tail_q      <= '0;
			fcount_q    <= '0;
			whead_q     <= '0;
			wfill_q     <= '0;
			sweep_row_q <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			fcount_q    <= fcount_d;
			whead_q     <= whead_d;
			wfill_q     <= wfill_d;
			sweep_row_q <= sweep_row_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		tag_q    <= tag_d;
		st_q     <= st_d;
		pop_cl_q <= pop_cl_d;
		op_q     <= op_d;
		if (emit) begin
			out_q <= emit_rsp;
		end
		if (wq_we) begin
			wcnt_q[wq_slot] <= q_op.count;
			wtag_q[wq_slot] <= q_op.tag;
		end
	end

	assign rsp_valid          = out_valid_q;
	assign rsp                = out_q;
	assign status.sweeping    = (state_q == S_SWEEP);
	assign status.free_count  = fcount_q;
	assign status.waiter_fill = wfill_q;

endmodule

### dv/testbench.sv
module testbench;
	import cfla_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
	localparam int CLUSTER_TOP   = NUM_CLUSTERS - 1;
	localparam int COUNT_TOP     = (1 << COUNT_W) - 1;
	localparam int TAG_TOP       = (1 << TAG_W) - 1;
	localparam int QUIET_LIMIT   = 4000;
	localparam int FREEZE_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	cluster_free_list_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	// allocator state as seen from outside
	logic [CLUSTER_W-1:0] ring_q [NUM_CLUSTERS];
	logic [RING_AW-1:0]   rd_ptr = '0;
	logic [RING_AW-1:0]   wr_ptr = '0;
	logic [FCOUNT_W-1:0]  n_free = '0;
	bit                   held [NUM_CLUSTERS];
	logic [COUNT_W-1:0]   wq_count [WAIT_DEPTH];
	logic [TAG_W-1:0]     wq_tag [WAIT_DEPTH];
	logic [WAW-1:0]       wq_head = '0;
	logic [WFILL_W-1:0]   wq_fill = '0;

	rsp_t step_rsp [$];
	rsp_t awaited_rsp [$];
	rsp_t head_rsp;

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;
	int quiet = 0;
	logic rx_frozen = 1'b0;
	event rx_freeze;

	function automatic void emit(input logic [STATUS_W-1:0] st, input logic [CLUSTER_W-1:0] cl,
			input logic [TAG_W-1:0] tg);
		rsp_t r;
		r.status = st;
		r.cluster_out = cl;
		r.tag_out = tg;
		r.last = 1'b0;
		step_rsp.push_back(r);
	endfunction

	function automatic logic [CLUSTER_W-1:0] take_cluster();
		logic [CLUSTER_W-1:0] c;
		c = ring_q[rd_ptr];
		rd_ptr++;
		n_free--;
		held[c] = 1'b1;
		return c;
	endfunction

	function automatic void put_cluster(input logic [CLUSTER_W-1:0] c);
		ring_q[wr_ptr] = c;
		wr_ptr++;
		n_free++;
	endfunction

	function automatic void grant_batch(input logic [COUNT_W-1:0] cnt, input logic [TAG_W-1:0] tg,
			input logic [STATUS_W-1:0] st);
		for (int i = 0; i < cnt; i++)
			emit(st, take_cluster(), tg);
	endfunction

	function automatic void wake_waiter();
		if (wq_fill != 0 && n_free >= wq_count[wq_head]) begin
			grant_batch(wq_count[wq_head], wq_tag[wq_head], ST_WAITER_GRANT);
			wq_head++;
			wq_fill--;
		end
	endfunction

	task automatic apply_request(input req_t w);
		logic [WAW-1:0] slot;
		bit out_of_range;
		out_of_range = int'(w.cluster) >= NUM_CLUSTERS;
		step_rsp.delete();
		case (w.func)
			FN_ALLOC: begin
				if (n_free == 0)
					emit(ST_NONE_FREE, '0, '0);
				else
					emit(ST_ALLOCATED, take_cluster(), '0);
			end
			FN_ALLOC_WAIT: begin
				if (w.count == 0 || w.count > MAX_BATCH || w.count > NUM_CLUSTERS) begin
					emit(ST_WAIT_REJECTED, '0, '0);
				end else if (wq_fill == 0 && n_free >= w.count) begin
					grant_batch(w.count, w.tag, ST_ALLOCATED);
				end else if (wq_fill >= WAIT_DEPTH) begin
					emit(ST_WAIT_REJECTED, '0, '0);
				end else begin
					slot = wq_head + WAW'(wq_fill);
					wq_count[slot] = w.count;
					wq_tag[slot] = w.tag;
					wq_fill++;
					emit(ST_QUEUED, '0, w.tag);
				end
			end
			FN_FREE: begin
				if (out_of_range || !held[w.cluster] || n_free >= NUM_CLUSTERS) begin
					emit(ST_BAD_FREE, w.cluster, '0);
				end else begin
					held[w.cluster] = 1'b0;
					put_cluster(w.cluster);
					emit(ST_FREED, w.cluster, '0);
					wake_waiter();
				end
			end
			FN_CLEAR: begin
				if (wq_fill != 0) begin
					emit(ST_CLEAR_REJECTED, '0, '0);
				end else begin
					foreach (held[i])
						held[i] = 1'b0;
					rd_ptr = '0;
					wr_ptr = '0;
					n_free = '0;
					emit(ST_LOADED, '0, '0);
				end
			end
			FN_LOAD_FREE: begin
				if (out_of_range || held[w.cluster] || n_free >= NUM_CLUSTERS) begin
					emit(ST_BAD_FREE, w.cluster, '0);
				end else begin
					put_cluster(w.cluster);
					emit(ST_LOADED, w.cluster, '0);
					wake_waiter();
				end
			end
			FN_LOAD_ALLOCATED: begin
				if (out_of_range) begin
					emit(ST_BAD_FREE, w.cluster, '0);
				end else begin
					held[w.cluster] = 1'b1;
					emit(ST_LOADED, w.cluster, '0);
				end
			end
			default: begin
			end
		endcase
		if (step_rsp.size() != 0)
			step_rsp[step_rsp.size() - 1].last = 1'b1;
		foreach (step_rsp[i])
			awaited_rsp.push_back(step_rsp[i]);
	endtask

	function automatic req_t pack_req(input logic [FUNC_W-1:0] f, input int c, input int n,
			input int t);
		req_t w;
		w.func = f;
		w.cluster = CLUSTER_W'(c);
		w.count = COUNT_W'(n);
		w.tag = TAG_W'(t);
		return w;
	endfunction

	function automatic req_t random_req();
		req_t w;
		w.func = FUNC_W'($urandom_range(FN_ALLOC, FN_LOAD_ALLOCATED));
		w.cluster = CLUSTER_W'($urandom);
		w.count = COUNT_W'($urandom);
		w.tag = TAG_W'($urandom);
		return w;
	endfunction

	function automatic logic [CLUSTER_W-1:0] pick_cluster(input bit want_held);
		int start;
		start = $urandom_range(CLUSTER_TOP);
		for (int i = 0; i < NUM_CLUSTERS; i++)
			if (held[(start + i) % NUM_CLUSTERS] == want_held)
				return CLUSTER_W'((start + i) % NUM_CLUSTERS);
		return CLUSTER_W'(start);
	endfunction

	task automatic send_word(input req_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		apply_request(w);
		n_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// load free clusters until every waiter has its batch, then empty the store
	task automatic release_waiters();
		while (wq_fill != 0)
			send_word(pack_req(FN_LOAD_FREE, pick_cluster(1'b0), 0, 0));
		send_word(pack_req(FN_CLEAR, 0, 0, 0));
	endtask

	task automatic test_directed();
		send_word(pack_req(FN_ALLOC, CLUSTER_TOP, COUNT_TOP, TAG_TOP));
		send_word(pack_req(FN_ALLOC_WAIT, 0, 0, 1));
		send_word(pack_req(FN_ALLOC_WAIT, 0, MAX_BATCH + 1, 2));
		send_word(pack_req(FN_ALLOC_WAIT, CLUSTER_TOP, COUNT_TOP, TAG_TOP));
		send_word(pack_req(FN_FREE, 0, 0, 0));
		send_word(pack_req(FN_LOAD_ALLOCATED, CLUSTER_TOP, 0, 0));
		send_word(pack_req(FN_LOAD_ALLOCATED, CLUSTER_TOP, 0, 0));
		send_word(pack_req(FN_LOAD_FREE, CLUSTER_TOP, 0, 0));
		send_word(pack_req(FN_FREE, CLUSTER_TOP, 0, 0));
		send_word(pack_req(FN_LOAD_FREE, 0, 0, 0));
		send_word(pack_req(FN_LOAD_FREE, 0, 0, 0));
		send_word(pack_req(FN_ALLOC_WAIT, 0, 1, 0));
		send_word(pack_req(FN_ALLOC_WAIT, 0, 4, TAG_TOP));
		send_word(pack_req(FN_ALLOC_WAIT, 0, 2, 'h5a));
		send_word(pack_req(FN_CLEAR, 0, 0, 0));
		send_word(pack_req(FN_ALLOC, 0, 0, 0));
		send_word(pack_req(FN_FREE, CLUSTER_TOP, 0, 0));
		send_word(pack_req(FN_UNUSED_LO, CLUSTER_TOP, COUNT_TOP, TAG_TOP));
		send_word(pack_req(FN_UNUSED_HI, CLUSTER_TOP, COUNT_TOP, TAG_TOP));
		send_word(pack_req(FN_LOAD_FREE, 1, 0, 0));
		send_word(pack_req(FN_LOAD_FREE, 2, 0, 0));
		send_word(pack_req(FN_FREE, 0, 0, 0));
		send_word(pack_req(FN_FREE, 1, 0, 0));
		send_word(pack_req(FN_CLEAR, 0, 0, 0));
		send_word(pack_req(FN_ALLOC, 0, 0, 0));
		drain();
	endtask

	task automatic test_waiter_queue();
		for (int i = 0; i <= WAIT_DEPTH; i++)
			send_word(pack_req(FN_ALLOC_WAIT, 0, $urandom_range(1, 3), $urandom));
		send_word(pack_req(FN_CLEAR, 0, 0, 0));
		release_waiters();
		drain();
	endtask

	task automatic test_load_and_batch();
		release_waiters();
		for (int c = 0; c < 2 * MAX_BATCH; c++)
			send_word(pack_req(FN_LOAD_FREE, c, 0, 0));
		send_word(pack_req(FN_LOAD_FREE, 7, 0, 0));
		send_word(pack_req(FN_LOAD_ALLOCATED, 500, 0, 0));
		send_word(pack_req(FN_LOAD_ALLOCATED, 500, 0, 0));
		send_word(pack_req(FN_LOAD_FREE, 500, 0, 0));
		send_word(pack_req(FN_FREE, 501, 0, 0));
		send_word(pack_req(FN_ALLOC_WAIT, 0, MAX_BATCH, 'hc3));
		send_word(pack_req(FN_ALLOC_WAIT, 0, MAX_BATCH, 'hc4));
		send_word(pack_req(FN_ALLOC_WAIT, 0, MAX_BATCH, 'hc5));
		for (int i = 0; i < MAX_BATCH - 1; i++)
			send_word(pack_req(FN_FREE, pick_cluster(1'b1), 0, 0));
		send_word(pack_req(FN_CLEAR, 0, 0, 0));
		drain();
	endtask

	task automatic test_output_stall();
		-> rx_freeze;
		for (int i = 0; i < 24; i++)
			send_word(random_req());
		drain();
	endtask

	task automatic test_random_mix(input int n_items);
		int done;
		int roll;
		req_t w;
		done = 0;
		while (done < n_items) begin
			w = random_req();
			roll = $urandom_range(99);
			if (roll < 18) begin
				w.func = FN_ALLOC;
			end else if (roll < 34) begin
				w.func = FN_ALLOC_WAIT;
				w.count = COUNT_W'($urandom_range(1, MAX_BATCH));
			end else if (roll < 60) begin
				w.func = FN_FREE;
				w.cluster = pick_cluster(1'b1);
			end else if (roll < 64) begin
				w.func = FN_FREE;
			end else if (roll < 82) begin
				w.func = FN_LOAD_FREE;
				w.cluster = pick_cluster(1'b0);
			end else if (roll < 88) begin
				w.func = FN_LOAD_ALLOCATED;
			end else if (roll < 92) begin
				w.func = FN_CLEAR;
			end else if (roll < 96) begin
				w.func = FN_ALLOC_WAIT;
				w.count = ($urandom_range(3) == 0) ? '0 :
					COUNT_W'($urandom_range(MAX_BATCH + 1, COUNT_TOP));
			end else if (roll < 98) begin
				w.func = FN_LOAD_FREE;
			end else begin
				w.func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
			end
			send_word(w);
			if (w.func <= FN_LOAD_ALLOCATED)
				done++;
		end
		drain();
	endtask

	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_frozen)
				rsp_ready <= 1'b0;
			else
				rsp_ready <= $urandom_range(99) >= rx_idle_pct;
		end
	end

	// hold the output side low for a long stretch
	initial begin
		forever begin
			@(rx_freeze);
			rx_frozen <= 1'b1;
			repeat (FREEZE_CYCLES) @(posedge clk);
			rx_frozen <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				$error("result word with nothing expected: status %0d cluster %0d tag %0d last %0b",
					rsp.status, rsp.cluster_out, rsp.tag_out, rsp.last);
				n_errors++;
			end else begin
				head_rsp = awaited_rsp[0];
				awaited_rsp.delete(0);
				check_field("status", 32'(head_rsp.status), 32'(rsp.status));
				check_field("cluster_out", 32'(head_rsp.cluster_out), 32'(rsp.cluster_out));
				check_field("tag_out", 32'(head_rsp.tag_out), 32'(rsp.tag_out));
				check_field("last", 32'(head_rsp.last), 32'(rsp.last));
			end
			n_checked++;
		end
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$error("no word moved for %0d cycles, %0d results outstanding", quiet,
				awaited_rsp.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		req_valid <= 1'b0;
		req <= '0;
		arst_n <= 1'b0;
		tx_idle_pct = 27;
		rx_idle_pct = 84;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_waiter_queue();
		test_random_mix(100);
		tx_idle_pct = 84;
		rx_idle_pct = 27;
		test_load_and_batch();
		test_output_stall();
		test_random_mix(100);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_mix(100);
		repeat (40) @(posedge clk);
		$display("Sent %0d request words and checked %0d result words under three idling mixes,",
			n_sent, n_checked);
		$display("with waiter overflow, batch grants and wakes and a long output stall among them.");
		if (n_errors == 0 && awaited_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
